@@ rtl/rhhc_pkg.sv @@
// ============================================================================
// rhhc_pkg - shared types and constants of the ramp/hold heater controller
// Codes, register indexes, reset values and field widths used by the core,
// its serial divider and its port checker.
// ============================================================================
package rhhc_pkg;

    // Field widths
    localparam int TEMP_W   = 10;
    localparam int SEC_W    = 16;
    localparam int DB_W     = 4;
    localparam int RAW_W    = 15;
    localparam int DIV_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Function codes of an input item
    localparam logic [1:0] FN_TICK  = 2'd0;
    localparam logic [1:0] FN_SENSE = 2'd1;
    localparam logic [1:0] FN_START = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SET_TEMP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEC_DEG   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIM  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 2'd3;

    // Register reset values
    localparam logic [TEMP_W-1:0] SET_TEMP_RST = 10'd55;
    localparam logic [SEC_W-1:0]  SEC_DEG_RST  = 16'd180;
    localparam logic [SEC_W-1:0]  HOLD_LIM_RST = 16'd3600;
    localparam logic [DB_W-1:0]   DEADBAND_RST = 4'd2;

    // Conversion: celsius = (2*raw - RAW_OFFSET) / RAW_SCALE
    localparam logic [DIV_W-1:0] RAW_SCALE  = 16'd100;
    localparam int               RAW_OFFSET = 27301;
    localparam int               TARGET_MAX = 511;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RAMP = 2'd1,
        PH_HOLD = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

endpackage

@@ rtl/ramp_hold_heater_controller_core.sv @@
// ============================================================================
// ramp_hold_heater_controller_core - two-stage ramp and hold heater control
// Takes tick, sensor and start items, tracks the ramp/hold program and drives
// the main and boost heater stages; one status item per input item.
// ============================================================================
// One item is worked at a time. A tick needs no conversion; a sensor or start item
// has its reading converted, and whenever the phase is ramp the item also has
// its ramp target worked out. Both use the single bit-serial 16-bit divider:
// once to divide the converted reading by 100 and once more to divide the ramp
// seconds by seconds_per_degree. The status item sits in an output register, so
// the next item is taken while it waits; the block holds off only when a new
// status item is ready and the previous one is still there.
module ramp_hold_heater_controller_core (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // read_ok[0], raw_reading[15:1]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // heater_main[0], heater_boost[1], phase[3:2],
                                        // sensor_error[4], measured_celsius[14:5],
                                        // target_celsius[24:15], zero[31:25]
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [rhhc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rhhc_pkg::CFG_DAT_W-1:0] cfg_data
);

    localparam int TW = rhhc_pkg::TEMP_W;
    localparam int SW = rhhc_pkg::SEC_W;

    typedef enum logic [2:0] {
        S_WAIT,
        S_CONV,
        S_PREP,
        S_RLOAD,
        S_RDIV,
        S_FINAL
    } state_t;

    // configuration
    logic [TW-1:0]             set_temp_reg;
    logic [SW-1:0]             sec_deg_reg;
    logic [SW-1:0]             hold_lim_reg;
    logic [rhhc_pkg::DB_W-1:0] deadband_reg;

    // controller state
    state_t                    state_reg, state_next;
    rhhc_pkg::phase_t          phase_reg, phase_next;
    logic signed [TW-1:0]      start_reg, start_next;
    logic [SW-1:0]             ramp_sec_reg, ramp_sec_next;
    logic [SW-1:0]             hold_sec_reg, hold_sec_next;
    logic signed [TW-1:0]      last_reg, last_next;
    logic [1:0]                heat_reg, heat_next;
    logic                      err_reg, err_next;

    // item in work
    logic [1:0]                func_reg, func_next;
    logic                      ok_reg, ok_next;
    logic                      neg_reg, neg_next;
    logic signed [TW-1:0]      cur_reg, cur_next;

    // output register
    logic                      out_valid_reg, out_valid_next;
    logic [31:0]               out_data_reg, out_data_next;

    // divider
    logic                      div_start;
    logic [rhhc_pkg::DIV_W-1:0] div_dividend, div_divisor;
    logic                      div_done;
    logic [rhhc_pkg::DIV_W-1:0] div_quo;

    logic                      in_fire;
    logic signed [17:0]        conv_x;
    logic [rhhc_pkg::DIV_W-1:0] conv_mag;
    logic [TW-1:0]             conv_q;
    logic signed [17:0]        ramp_sum;
    logic signed [TW-1:0]      ramp_tgt;
    logic signed [TW-1:0]      set_temp_s;
    logic signed [TW-1:0]      out_tgt;

    function automatic logic [1:0] ctl(input logic signed [TW-1:0] cur,
                                       input logic signed [TW-1:0] tgt,
                                       input logic [rhhc_pkg::DB_W-1:0] db,
                                       input logic [1:0] bits);
        logic signed [TW:0] diff;
        logic signed [TW:0] dbs;
        logic [1:0]         res;
        diff = TW'(0) + (TW+1)'(cur) - (TW+1)'(tgt);
        dbs  = $signed({{(TW+1-rhhc_pkg::DB_W){1'b0}}, db});
        if (cur > tgt)
            res = (diff >= dbs) ? 2'b00 : (bits & 2'b01);
        else
            res = (-diff >= dbs) ? 2'b11 : (bits | 2'b01);
        return res;
    endfunction

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_WAIT);
    assign cfg_ready     = 1'b1;
    assign set_temp_s    = $signed(set_temp_reg);

    // signed dividend of the conversion, taken apart into sign and magnitude
    assign conv_x   = $signed({2'b00, s_axis_tdata[15:1], 1'b0})
                      - 18'sd27301;
    assign conv_mag = conv_x[17] ? rhhc_pkg::DIV_W'(-conv_x)
                                 : rhhc_pkg::DIV_W'(conv_x);
    assign conv_q   = div_quo[TW-1:0];

    assign ramp_sum = $signed({{(18-TW){start_reg[TW-1]}}, start_reg})
                      + $signed({2'b00, div_quo});
    assign ramp_tgt = (ramp_sum > 18'sd511) ? TW'(rhhc_pkg::TARGET_MAX)
                                            : ramp_sum[TW-1:0];

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = conv_mag;
        div_divisor  = rhhc_pkg::RAW_SCALE;
        if (state_reg == S_RLOAD)
        begin
            div_dividend = ramp_sec_reg;
            div_divisor  = (sec_deg_reg == '0) ? rhhc_pkg::DIV_W'(1) : sec_deg_reg;
            div_start    = (phase_reg == rhhc_pkg::PH_RAMP);
        end
        else if (in_fire)
        begin
            div_start = (s_axis_tuser == rhhc_pkg::FN_SENSE)
                        || (s_axis_tuser == rhhc_pkg::FN_START);
        end
    end

    rhhc_sdiv u_sdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        start_next     = start_reg;
        ramp_sec_next  = ramp_sec_reg;
        hold_sec_next  = hold_sec_reg;
        last_next      = last_reg;
        heat_next      = heat_reg;
        err_next       = err_reg;
        func_next      = func_reg;
        ok_next        = ok_reg;
        neg_next       = neg_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_tgt        = '0;

        if (m_axis_tvalid && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_WAIT:
            begin
                if (in_fire)
                begin
                    func_next  = s_axis_tuser;
                    ok_next    = s_axis_tdata[0];
                    neg_next   = conv_x[17];
                    state_next = div_start ? S_CONV : S_PREP;
                end
            end
            S_CONV:
            begin
                if (div_done)
                begin
                    cur_next   = neg_reg ? -$signed(conv_q) : $signed(conv_q);
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                case (func_reg)
                    rhhc_pkg::FN_TICK:
                    begin
                        if (phase_reg == rhhc_pkg::PH_RAMP && ramp_sec_reg != '1)
                            ramp_sec_next = ramp_sec_reg + 1'b1;
                        else if (phase_reg == rhhc_pkg::PH_HOLD && hold_sec_reg != '1)
                            hold_sec_next = hold_sec_reg + 1'b1;
                    end
                    rhhc_pkg::FN_START:
                    begin
                        if (ok_reg)
                        begin
                            start_next = cur_reg;
                            last_next  = cur_reg;
                            err_next   = 1'b0;
                        end
                        else
                        begin
                            start_next = '0;
                            err_next   = 1'b1;
                        end
                        ramp_sec_next = '0;
                        hold_sec_next = '0;
                        heat_next     = 2'b00;
                        phase_next    = rhhc_pkg::PH_RAMP;
                    end
                    rhhc_pkg::FN_SENSE:
                    begin
                        if (ok_reg)
                        begin
                            last_next = cur_reg;
                            err_next  = 1'b0;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                state_next = S_RLOAD;
            end
            S_RLOAD:
            begin
                state_next = (phase_reg == rhhc_pkg::PH_RAMP) ? S_RDIV : S_FINAL;
            end
            S_RDIV:
            begin
                if (div_done)
                    state_next = S_FINAL;
            end
            S_FINAL:
            begin
                // hold while the previous result item is still waiting
                if (!out_valid_reg || m_axis_tready)
                begin
                    if (func_reg == rhhc_pkg::FN_SENSE && ok_reg)
                    begin
                        if (phase_reg == rhhc_pkg::PH_RAMP)
                        begin
                            if (cur_reg >= set_temp_s)
                                phase_next = rhhc_pkg::PH_HOLD;
                            heat_next = ctl(cur_reg, ramp_tgt, deadband_reg, heat_reg);
                        end
                        else if (phase_reg == rhhc_pkg::PH_HOLD)
                        begin
                            if (hold_sec_reg >= hold_lim_reg)
                            begin
                                heat_next  = 2'b00;
                                phase_next = rhhc_pkg::PH_DONE;
                            end
                            else
                            begin
                                heat_next = ctl(cur_reg, set_temp_s, deadband_reg,
                                                heat_reg);
                            end
                        end
                    end
                    if (phase_next == rhhc_pkg::PH_RAMP)
                        out_tgt = ramp_tgt;
                    else if (phase_next == rhhc_pkg::PH_HOLD)
                        out_tgt = set_temp_s;
                    out_data_next  = {7'd0, out_tgt, last_reg, err_reg,
                                      phase_next, heat_next[1], heat_next[0]};
                    out_valid_next = 1'b1;
                    state_next     = S_WAIT;
                end
            end
            default:
            begin
                state_next = S_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_temp_reg  <= rhhc_pkg::SET_TEMP_RST;
            sec_deg_reg   <= rhhc_pkg::SEC_DEG_RST;
            hold_lim_reg  <= rhhc_pkg::HOLD_LIM_RST;
            deadband_reg  <= rhhc_pkg::DEADBAND_RST;
            state_reg     <= S_WAIT;
            phase_reg     <= rhhc_pkg::PH_IDLE;
            start_reg     <= '0;
            ramp_sec_reg  <= '0;
            hold_sec_reg  <= '0;
            last_reg      <= '0;
            heat_reg      <= 2'b00;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rhhc_pkg::REG_SET_TEMP: set_temp_reg <= cfg_data[TW-1:0];
                    rhhc_pkg::REG_SEC_DEG:  sec_deg_reg  <= cfg_data[SW-1:0];
                    rhhc_pkg::REG_HOLD_LIM: hold_lim_reg <= cfg_data[SW-1:0];
                    rhhc_pkg::REG_DEADBAND: deadband_reg <= cfg_data[rhhc_pkg::DB_W-1:0];
                    default:                set_temp_reg <= set_temp_reg;
                endcase
            end
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            start_reg     <= start_next;
            ramp_sec_reg  <= ramp_sec_next;
            hold_sec_reg  <= hold_sec_next;
            last_reg      <= last_next;
            heat_reg      <= heat_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        ok_reg       <= ok_next;
        neg_reg      <= neg_next;
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

@@ rtl/rhhc_sdiv.sv @@
// ============================================================================
// rhhc_sdiv - bit-serial restoring divider
// Unsigned quotient of a DIV_W-bit dividend by a DIV_W-bit divisor, one
// quotient bit per cycle. done pulses once the quotient is final; the
// quotient holds until the next start.
// ============================================================================
module rhhc_sdiv (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [rhhc_pkg::DIV_W-1:0] dividend,
    input  logic [rhhc_pkg::DIV_W-1:0] divisor,
    output logic                     done,
    output logic [rhhc_pkg::DIV_W-1:0] quotient
);

    localparam int W     = rhhc_pkg::DIV_W;
    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [W:0] shifted;
    logic [W:0] trial;
    logic       fits;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract when the divisor fits
            rem_next = fits ? trial[W-1:0] : shifted[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/rhhc_checker.sv @@
// ============================================================================
// rhhc_checker - port checks of the ramp/hold heater controller
// Watches the core's ports and flags results or handshakes that the
// controller must never show.
// ============================================================================
module rhhc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [rhhc_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [rhhc_pkg::CFG_DAT_W-1:0] cfg_data
);

    // a waiting result item holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    // one item at a time: no second item right after one is taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken on two cycles in a row");

    // idle and done drive no heater and report a zero target
    a_idle_done_off: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[3:2] == rhhc_pkg::PH_IDLE
                          || m_axis_tdata[3:2] == rhhc_pkg::PH_DONE)
        |-> m_axis_tdata[1:0] == 2'b00 && m_axis_tdata[24:15] == 10'd0)
        else $error("heater on or target set outside ramp and hold");

    // padding above the target field stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:25] == 7'd0)
        else $error("result padding bits not zero");

endmodule

bind ramp_hold_heater_controller_core rhhc_checker u_rhhc_checker (.*);

@@ dv/ramp_hold_heater_controller_core_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ramp_hold_heater_controller_core_tb - self-checking bench for the heater core
// Drives tick, sensor and start items through the input stream. A behavioral
// copy of the ramp/hold controller predicts each status item but those of typed
// table rows, which carry their own, and each is compared field by field. A short
// directed table comes first. Random ramp/hold programs follow under six register
// settings, with random input idle gaps and output back-pressure in the first four.
// ============================================================================
module ramp_hold_heater_controller_core_tb;

    import rhhc_pkg::*;

    localparam logic [1:0] FN_NOP      = 2'd3;  // function code the core ignores
    localparam int         SEC_SAT     = (1 << SEC_W) - 1;
    localparam int         CELSIUS_MIN = -273;
    localparam int         CELSIUS_MAX = 382;
    localparam int         SETTLE_CYC  = 40;
    localparam int         CYCLE_LIMIT = 500000;
    localparam int         DIR_ROWS    = 23;

    // status item, last field in the lowest bits as on m_axis_tdata
    typedef struct packed {
        logic signed [TEMP_W-1:0] tgt;
        logic signed [TEMP_W-1:0] meas;
        logic                     err;
        phase_t                   ph;
        logic                     stage_boost;
        logic                     stage_main;
    } status_t;

    typedef struct packed {
        logic [1:0]       fn;
        logic             ok;
        logic [RAW_W-1:0] raw;
        logic             typed;
        status_t          want;
    } stim_row_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata  = '0;
    logic [1:0]           s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [31:0]          m_axis_tdata;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [CFG_DAT_W-1:0] cfg_data      = '0;

    // controller copy: configuration
    logic signed [TEMP_W-1:0] cfg_set_temp    = SET_TEMP_RST;
    logic [SEC_W-1:0]         cfg_sec_per_deg = SEC_DEG_RST;
    logic [SEC_W-1:0]         cfg_hold_limit  = HOLD_LIM_RST;
    logic [DB_W-1:0]          cfg_deadband    = DEADBAND_RST;

    // controller copy: program state
    phase_t     ctl_phase = PH_IDLE;
    int         start_c   = 0;
    int         ramp_secs = 0;
    int         hold_secs = 0;
    int         last_c    = 0;
    logic [1:0] heat      = 2'b00;     // bit 0 main, bit 1 boost
    logic       sens_err  = 1'b0;

    status_t status_q[$];

    int send_idle_pct  = 11;
    int recv_idle_pct  = 65;
    int items_sent     = 0;
    int directed_items = 0;
    int results_seen   = 0;
    int hold_entries   = 0;
    int done_entries   = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    // pattern order of want: tgt, meas, err, ph, boost, main
    // typed rows assume set 30 C, 1 s per degree, hold limit 2 s, deadband 3
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{FN_TICK,  1'b0, 15'h5555, 1'b1, '{10'sd0, 10'sd0, 1'b0, PH_IDLE, 1'b0, 1'b0}},
        '{FN_SENSE, 1'b1, 15'd0,    1'b1, '{10'sd0, -10'sd273, 1'b0, PH_IDLE, 1'b0, 1'b0}},
        '{FN_SENSE, 1'b1, 15'h7FFF, 1'b1, '{10'sd0, 10'sd382, 1'b0, PH_IDLE, 1'b0, 1'b0}},
        '{FN_SENSE, 1'b0, 15'h7FFF, 1'b1, '{10'sd0, 10'sd382, 1'b1, PH_IDLE, 1'b0, 1'b0}},
        '{FN_NOP,   1'b1, 15'h2AAA, 1'b1, '{10'sd0, 10'sd382, 1'b1, PH_IDLE, 1'b0, 1'b0}},
        '{FN_START, 1'b0, 15'h7FFF, 1'b1, '{10'sd0, 10'sd382, 1'b1, PH_RAMP, 1'b0, 1'b0}},
        '{FN_START, 1'b1, 15'd14651, 1'b1, '{10'sd20, 10'sd20, 1'b0, PH_RAMP, 1'b0, 1'b0}},
        '{FN_TICK,  1'b1, 15'h2AAA, 1'b0, '0},
        '{FN_TICK,  1'b0, 15'h5555, 1'b0, '0},
        '{FN_SENSE, 1'b1, 15'd14751, 1'b0, '0},   // on target: main only
        '{FN_SENSE, 1'b1, 15'd14951, 1'b0, '0},   // far above: both off
        '{FN_SENSE, 1'b1, 15'd14151, 1'b0, '0},   // far below: both on
        '{FN_SENSE, 1'b1, 15'd14851, 1'b0, '0},   // slightly above: boost off
        '{FN_SENSE, 1'b1, 15'd15151, 1'b0, '0},   // reaches set point: hold
        '{FN_SENSE, 1'b1, 15'd14901, 1'b0, '0},
        '{FN_TICK,  1'b0, 15'd0,    1'b0, '0},
        '{FN_SENSE, 1'b0, 15'd0,    1'b0, '0},
        '{FN_TICK,  1'b1, 15'h7FFF, 1'b0, '0},
        '{FN_SENSE, 1'b1, 15'd15201, 1'b0, '0},   // hold limit met: done
        '{FN_SENSE, 1'b1, 15'd15651, 1'b0, '0},
        '{FN_TICK,  1'b1, 15'd0,    1'b0, '0},
        '{FN_START, 1'b1, 15'd0,    1'b1, '{-10'sd273, -10'sd273, 1'b0, PH_RAMP, 1'b0, 1'b0}},
        '{FN_SENSE, 1'b1, 15'd0,    1'b0, '0}
    };

    ramp_hold_heater_controller_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int raw_to_celsius(input logic [RAW_W-1:0] raw);
        int r;
        r = int'(raw);
        return (2 * r - RAW_OFFSET) / int'(RAW_SCALE);
    endfunction

    // land 2*raw - offset just inside the wanted whole degree
    function automatic logic [RAW_W-1:0] celsius_to_raw(input int c);
        int v;
        v = (c < CELSIUS_MIN) ? CELSIUS_MIN : (c > CELSIUS_MAX) ? CELSIUS_MAX : c;
        return RAW_W'((v < 0) ? 50 * v + 13650 : 50 * v + 13651);
    endfunction

    function automatic int ramp_target();
        int div;
        int t;
        div = (cfg_sec_per_deg == '0) ? 1 : int'(cfg_sec_per_deg);
        t = start_c + ramp_secs / div;
        return (t > TARGET_MAX) ? TARGET_MAX : t;
    endfunction

    // inside the deadband touch one stage only, past it switch both
    function automatic void regulate(input int cur, input int tgt);
        int db;
        db = int'(cfg_deadband);
        if (cur > tgt)
        begin
            if (cur - tgt >= db)
                heat = 2'b00;
            else
                heat[1] = 1'b0;
        end
        else
        begin
            if (tgt - cur >= db)
                heat = 2'b11;
            else
                heat[0] = 1'b1;
        end
    endfunction

    function automatic status_t advance_controller(input logic [1:0] fn, input logic ok,
                                                   input logic [RAW_W-1:0] raw);
        status_t st;
        int      cur;
        int      tgt;
        int      setc;
        setc = cfg_set_temp;
        case (fn)
            FN_TICK:
            begin
                if (ctl_phase == PH_RAMP && ramp_secs < SEC_SAT)
                    ramp_secs++;
                else if (ctl_phase == PH_HOLD && hold_secs < SEC_SAT)
                    hold_secs++;
            end
            FN_START:
            begin
                if (ok)
                begin
                    start_c  = raw_to_celsius(raw);
                    last_c   = start_c;
                    sens_err = 1'b0;
                end
                else
                begin
                    start_c  = 0;
                    sens_err = 1'b1;
                end
                ramp_secs = 0;
                hold_secs = 0;
                heat      = 2'b00;
                ctl_phase = PH_RAMP;
            end
            FN_SENSE:
            begin
                if (!ok)
                    sens_err = 1'b1;
                else
                begin
                    cur      = raw_to_celsius(raw);
                    last_c   = cur;
                    sens_err = 1'b0;
                    if (ctl_phase == PH_RAMP)
                    begin
                        // control on the ramp target even on the step into hold
                        tgt = ramp_target();
                        if (cur >= setc)
                        begin
                            ctl_phase = PH_HOLD;
                            hold_entries++;
                        end
                        regulate(cur, tgt);
                    end
                    else if (ctl_phase == PH_HOLD)
                    begin
                        if (hold_secs >= int'(cfg_hold_limit))
                        begin
                            heat      = 2'b00;
                            ctl_phase = PH_DONE;
                            done_entries++;
                        end
                        else
                            regulate(cur, setc);
                    end
                end
            end
            default: ;
        endcase

        tgt = 0;
        if (ctl_phase == PH_RAMP)
            tgt = ramp_target();
        else if (ctl_phase == PH_HOLD)
            tgt = setc;

        st.stage_main  = heat[0];
        st.stage_boost = heat[1];
        st.ph          = ctl_phase;
        st.err         = sens_err;
        st.meas        = TEMP_W'(last_c);
        st.tgt         = TEMP_W'(tgt);
        return st;
    endfunction

    task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                   input logic signed [31:0] want);
        $display("[%0t] status item %0d: %s is %0d, expected %0d",
                 $time, results_seen, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_item(input logic [1:0] fn, input logic ok, input logic [RAW_W-1:0] raw,
                             input logic typed = 1'b0, input status_t typed_want = '0);
        status_t predicted;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {raw, ok};
        s_axis_tuser  <= fn;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = advance_controller(fn, ok, raw);
        status_q.push_back(typed ? typed_want : predicted);
        if (fn != FN_NOP)
            items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_SET_TEMP: cfg_set_temp    = data[TEMP_W-1:0];
            REG_SEC_DEG:  cfg_sec_per_deg = data;
            REG_HOLD_LIM: cfg_hold_limit  = data;
            REG_DEADBAND: cfg_deadband    = data[DB_W-1:0];
        endcase
    endtask

    // unused upper data bits get random filler
    task automatic apply_settings(input logic signed [TEMP_W-1:0] set_c,
                                  input logic [SEC_W-1:0] spd,
                                  input logic [SEC_W-1:0] hold_lim,
                                  input logic [DB_W-1:0] dband);
        write_reg(REG_SET_TEMP, {6'($urandom()), set_c});
        write_reg(REG_SEC_DEG, spd);
        write_reg(REG_HOLD_LIM, hold_lim);
        write_reg(REG_DEADBAND, {12'($urandom()), dband});
        cfg_valid <= 1'b0;
    endtask

    // drop valid, let every status item come back, then let the core settle
    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // one heating program: start, then ticks and readings, most near the plant or set point
    task automatic run_program(input int n);
        int plant;
        int setc;
        int span;
        int reading;
        int r;
        setc  = cfg_set_temp;
        plant = setc - int'($urandom_range(0, 25));
        if ($urandom_range(9) == 0)
            send_item(FN_START, 1'b0, RAW_W'($urandom()));
        else
            send_item(FN_START, 1'b1, celsius_to_raw(plant));
        repeat (n)
        begin
            r    = $urandom_range(99);
            span = int'(cfg_deadband) + 3;
            if (r < 40)
                send_item(FN_TICK, 1'($urandom()), RAW_W'($urandom()));
            else if (r < 86)
            begin
                plant   = plant + int'($urandom_range(0, 4)) - 1;
                reading = (ctl_phase == PH_HOLD) ? setc : plant;
                reading = reading + int'($urandom_range(0, 2 * span)) - span;
                send_item(FN_SENSE, 1'b1, celsius_to_raw(reading));
            end
            else if (r < 92)
                send_item(FN_SENSE, 1'b0, RAW_W'($urandom()));
            else if (r < 96)
                send_item(FN_SENSE, 1'b1, RAW_W'($urandom()));
            else if (r < 98)
                send_item(FN_NOP, 1'($urandom()), RAW_W'($urandom()));
            else
                send_item(FN_START, 1'b1, RAW_W'($urandom()));
        end
    endtask

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin : status_check
        status_t got;
        status_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = status_t'(m_axis_tdata[24:0]);
            if (status_q.size() == 0)
                report_mismatch("status item with nothing outstanding", m_axis_tdata, 0);
            else
            begin
                want = status_q.pop_front();
                if (got.stage_main !== want.stage_main)
                    report_mismatch("heater_main", got.stage_main, want.stage_main);
                if (got.stage_boost !== want.stage_boost)
                    report_mismatch("heater_boost", got.stage_boost, want.stage_boost);
                if (got.ph !== want.ph)
                    report_mismatch("phase", got.ph, want.ph);
                if (got.err !== want.err)
                    report_mismatch("sensor_error", got.err, want.err);
                if (got.meas !== want.meas)
                    report_mismatch("measured_celsius", got.meas, want.meas);
                if (got.tgt !== want.tgt)
                    report_mismatch("target_celsius", got.tgt, want.tgt);
                if (m_axis_tdata[31:25] !== '0)
                    report_mismatch("pad bits", m_axis_tdata[31:25], 0);
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d status items outstanding",
                     cycle_count, status_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int seg;
        int seg_end;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        apply_settings(10'sd30, 16'd1, 16'd2, 4'd3);
        for (int i = 0; i < DIR_ROWS; i++)
            send_item(dir_rows[i].fn, dir_rows[i].ok, dir_rows[i].raw,
                      dir_rows[i].typed, dir_rows[i].want);
        directed_items = items_sent;

        for (seg = 0; seg < 6; seg++)
        begin
            drain_and_settle();
            send_idle_pct = (seg < 2) ? 11 : (seg < 4) ? 65 : 0;
            recv_idle_pct = (seg < 2) ? 65 : (seg < 4) ? 11 : 0;
            case (seg)
                0: apply_settings(-10'sd40, 16'd0, 16'd0, 4'd0);
                2: apply_settings(10'sd380, 16'hFFFF, 16'hFFFF, 4'd15);
                3: apply_settings(10'sd380, 16'd1, 16'($urandom_range(0, 30)),
                                  4'($urandom_range(1, 15)));
                default: apply_settings(10'(int'($urandom_range(0, 420)) - 40),
                                        16'($urandom_range(1, 6)),
                                        16'($urandom_range(0, 30)),
                                        4'($urandom_range(1, 15)));
            endcase
            if (seg == 3)
            begin
                // start hot and tick long enough to pin the ramp target at its ceiling
                send_item(FN_START, 1'b1, 15'h7FFF);
                repeat (135) send_item(FN_TICK, 1'($urandom()), RAW_W'($urandom()));
            end
            seg_end = items_sent + 30;
            while (items_sent < seg_end)
                run_program($urandom_range(6, 30));
        end

        drain_and_settle();
        $display("Ran %0d input items (%0d directed) under seven register settings in %0d cycles",
                 items_sent, directed_items, cycle_count);
        $display("Checked %0d status items; hold entered %0d times, done %0d times, %0d mismatches",
                 results_seen, hold_entries, done_entries, mismatch_count);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/rhhc_pkg.sv
rtl/rhhc_sdiv.sv
rtl/ramp_hold_heater_controller_core.sv
rtl/rhhc_checker.sv
dv/ramp_hold_heater_controller_core_tb.sv
